// ----- rtl/rre_pkg.sv -----
// Shared types and constants for the respiration rate estimator.
package rre_pkg;

    localparam int RATE_W   = 10;
    localparam int STATUS_W = 3;
    localparam int BPM_W    = 5;
    localparam int CONF_W   = 7;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(25);

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CFG   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FEW_PEAKS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // envelope: (16*|x| + 240*env) >> 8
    localparam int ENV_NEW_SH = 4;
    localparam int ENV_SH     = 8;

    localparam int GAP_LO_S     = 2;
    localparam int GAP_HI_S     = 10;
    localparam int MIN_WINDOW_S = 20;
    localparam int SEC_PER_MIN  = 60;
    localparam int BPM_MIN      = 6;
    localparam int BPM_MAX      = 30;
    localparam int CONF_STEP    = 25;
    localparam int CONF_MAX     = 100;
    localparam int CONF_FULL_N  = 4;
    localparam int MIN_INTERVALS = 2;

    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

// ----- rtl/respiration_rate_estimator.sv -----
// Respiration rate estimator: envelope, peak intervals, rate and confidence.
//
// Each accepted sample passes accept, envelope update and peak check; no new
// sample is taken before the peak check is done, and a sample past MAX_SAMPLES
// is dropped. After the sample flagged last, the one shared bit-serial divider
// (DIV_W = 16 at the default parameters) computes first the mean interval and
// then the rate, and no sample is taken meanwhile; the result waits in an
// output register, and samples of the next window are taken while it waits.
// The sample rate register may be written only while idle.
module respiration_rate_estimator import rre_pkg::*; #(
    parameter int MAX_SAMPLES = 65535,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RATE_W-1:0]      i_cfg_sample_rate_hz,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_ac_sample,
    input  logic                   i_last_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [BPM_W-1:0]       o_breaths_per_minute,
    output logic [CONF_W-1:0]      o_confidence_percent
);

    localparam int SB    = SAMPLE_BITS;
    localparam int SUM_W = SB + ENV_SH;
    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
    localparam int LO_W  = RATE_W + 2;
    localparam int HI_W  = RATE_W + 4;
    localparam int WIN_W = RATE_W + 5;
    localparam int P60_W = RATE_W + 6;
    localparam int DIV_W = (IDX_W > P60_W) ? IDX_W : P60_W;
    localparam int CMP_W = (IDX_W > WIN_W) ? IDX_W : WIN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ENV   = 3'd1;
    localparam logic [2:0] S_PEAK  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV1  = 3'd4;
    localparam logic [2:0] S_DIV2  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [RATE_W-1:0]   r_rate;
    logic [SB-1:0]       r_mag, n_mag;
    logic                r_last, n_last;
    logic [SB-1:0]       r_env, n_env;
    logic [SB-1:0]       r_prev, n_prev;
    logic                r_was, n_was;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_anchor, n_anchor;
    logic [IDX_W-1:0]    r_total, n_total;
    logic [IDX_W-1:0]    r_count, n_count;
    logic [STATUS_W-1:0] r_res_st, n_res_st;
    logic [BPM_W-1:0]    r_res_bpm, n_res_bpm;
    logic [CONF_W-1:0]   r_res_conf, n_res_conf;
    logic                r_ovalid, n_ovalid;
    logic [STATUS_W-1:0] r_ost, n_ost;
    logic [BPM_W-1:0]    r_obpm, n_obpm;
    logic [CONF_W-1:0]   r_oconf, n_oconf;

    logic [SB-1:0]       in_mag;
    logic [SUM_W-1:0]    env_sum;
    logic                rising;
    logic [IDX_W-1:0]    gap;
    logic [LO_W-1:0]     gap_lo;
    logic [HI_W-1:0]     gap_hi;
    logic [CMP_W-1:0]    win_min;
    logic [P60_W-1:0]    rate60;
    logic                in_acc;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic [DIV_W-1:0]    div_a, div_b, div_q;

    rre_div #(.W(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_rsp      (div_rsp),
        .o_quotient (div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;

    assign in_mag  = i_ac_sample[SB-1] ? (~i_ac_sample + 1'b1) : i_ac_sample;
    assign env_sum = (SUM_W'(r_mag) << ENV_NEW_SH) + (SUM_W'(r_env) << ENV_SH)
                   - (SUM_W'(r_env) << ENV_NEW_SH);
    assign rising  = r_env > r_prev;
    assign gap     = r_idx - r_anchor;
    assign gap_lo  = LO_W'(r_rate) * LO_W'(GAP_LO_S);
    assign gap_hi  = HI_W'(r_rate) * HI_W'(GAP_HI_S);
    assign win_min = CMP_W'(r_rate) * CMP_W'(MIN_WINDOW_S);
    assign rate60  = P60_W'(r_rate) * P60_W'(SEC_PER_MIN);

    always_comb begin
        n_state    = r_state;
        n_mag      = r_mag;
        n_last     = r_last;
        n_env      = r_env;
        n_prev     = r_prev;
        n_was      = r_was;
        n_idx      = r_idx;
        n_anchor   = r_anchor;
        n_total    = r_total;
        n_count    = r_count;
        n_res_st   = r_res_st;
        n_res_bpm  = r_res_bpm;
        n_res_conf = r_res_conf;
        n_ovalid   = r_ovalid;
        n_ost      = r_ost;
        n_obpm     = r_obpm;
        n_oconf    = r_oconf;
        div_req.start = 1'b0;
        div_a      = DIV_W'(r_total);
        div_b      = DIV_W'(r_count);

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mag  = in_mag;
                    n_last = i_last_sample;
                    if (32'(r_idx) < MAX_SAMPLES) begin
                        n_state = S_ENV;
                    end else if (i_last_sample) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_ENV: begin
                n_env   = env_sum[SUM_W-1 -: SB];
                n_state = S_PEAK;
            end
            S_PEAK: begin
                if (!rising && r_was && r_idx != '0) begin
                    if (r_anchor == '0) begin
                        n_anchor = r_idx;
                    end else if (32'(gap) >= 32'(gap_lo) && 32'(gap) <= 32'(gap_hi)) begin
                        n_total  = r_total + gap;
                        n_count  = r_count + 1'b1;
                        n_anchor = r_idx;
                    end
                end
                n_prev  = r_env;
                n_was   = rising;
                n_idx   = r_idx + 1'b1;
                n_state = r_last ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                n_res_bpm  = '0;
                n_res_conf = '0;
                if (r_rate == '0) begin
                    n_res_st = ST_BAD_CFG;
                    n_state  = S_OUT;
                end else if (CMP_W'(r_idx) < win_min) begin
                    n_res_st = ST_SHORT;
                    n_state  = S_OUT;
                end else if (32'(r_count) < MIN_INTERVALS) begin
                    n_res_st = ST_FEW_PEAKS;
                    n_state  = S_OUT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV1;
                end
            end
            S_DIV1: begin
                div_a = DIV_W'(rate60);
                div_b = div_q;
                if (div_rsp.done) begin
                    if (div_q == '0) begin
                        n_res_st = ST_BAD_CFG;
                        n_state  = S_OUT;
                    end else begin
                        div_req.start = 1'b1;
                        n_state       = S_DIV2;
                    end
                end
            end
            S_DIV2: begin
                if (div_rsp.done) begin
                    if (div_q < DIV_W'(BPM_MIN) || div_q > DIV_W'(BPM_MAX)) begin
                        n_res_st = ST_RANGE;
                    end else begin
                        n_res_st  = ST_OK;
                        n_res_bpm = BPM_W'(div_q);
                        if (32'(r_count) >= CONF_FULL_N) begin
                            n_res_conf = CONF_W'(CONF_MAX);
                        end else begin
                            n_res_conf = CONF_W'(r_count) * CONF_W'(CONF_STEP);
                        end
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_obpm   = r_res_bpm;
                    n_oconf  = r_res_conf;
                    n_env    = '0;
                    n_prev   = '0;
                    n_was    = 1'b0;
                    n_idx    = '0;
                    n_anchor = '0;
                    n_total  = '0;
                    n_count  = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rate   <= RATE_RESET;
            r_env    <= '0;
            r_prev   <= '0;
            r_was    <= 1'b0;
            r_idx    <= '0;
            r_anchor <= '0;
            r_total  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rate <= i_cfg_sample_rate_hz;
            end
            r_env    <= n_env;
            r_prev   <= n_prev;
            r_was    <= n_was;
            r_idx    <= n_idx;
            r_anchor <= n_anchor;
            r_total  <= n_total;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_mag      <= n_mag;
        r_last     <= n_last;
        r_res_st   <= n_res_st;
        r_res_bpm  <= n_res_bpm;
        r_res_conf <= n_res_conf;
        r_ost      <= n_ost;
        r_obpm     <= n_obpm;
        r_oconf    <= n_oconf;
    end

    assign o_valid              = r_ovalid;
    assign o_status             = r_ost;
    assign o_breaths_per_minute = r_obpm;
    assign o_confidence_percent = r_oconf;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_breaths_per_minute == '0 && o_confidence_percent == '0))
        else $error("nonzero rate or confidence on a failed window");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |->
            (32'(o_breaths_per_minute) >= BPM_MIN && 32'(o_breaths_per_minute) <= BPM_MAX
             && o_confidence_percent != '0))
        else $error("ok beat with rate out of range");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV1 || r_state == S_DIV2) && !div_rsp.done) |-> div_rsp.busy)
        else $error("sequencer waits on an idle divider");

    a_peaks_need_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_anchor != '0))
        else $error("accepted interval without an anchor");

endmodule

// ----- rtl/rre_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module rre_div import rre_pkg::*; #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_div_req     i_req,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output t_div_rsp     o_rsp,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_q, n_q;
    logic [W-1:0]     r_dvs, n_dvs;
    logic [W:0]       trial;

    always_comb begin
        trial  = {r_rem, r_q[W-1]} - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(W - 1);
            n_rem  = '0;
            n_q    = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!trial[W]) begin
                n_rem = trial[W-1:0];
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[W-2:0], r_q[W-1]};
                n_q   = {r_q[W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quotient = r_q;

endmodule

// ----- test/rre_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the respiration rate estimator: tracks windows, predicts and compares.
module rre_result_checker import rre_pkg::*; #(
    parameter int MAX_SAMPLES = 65535,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [RATE_W-1:0]      i_cfg_rate,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [STATUS_W-1:0]    i_status,
    input  logic [BPM_W-1:0]       i_bpm,
    input  logic [CONF_W-1:0]      i_conf,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_ok_results
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BPM_W-1:0]    bpm;
        logic [CONF_W-1:0]   conf;
    } t_rate_report;

    t_rate_report reports_due[$];

    logic [RATE_W-1:0]      rate_hz;
    logic [SAMPLE_BITS-1:0] env;
    logic [SAMPLE_BITS-1:0] env_prev;
    logic                   rose_prev;
    int unsigned            n_taken;
    int unsigned            anchor;
    int unsigned            gap_sum;
    int unsigned            n_gaps;

    task automatic clear_window();
        env        = '0;
        env_prev   = '0;
        rose_prev  = 1'b0;
        n_taken    = 0;
        anchor     = 0;
        gap_sum    = 0;
        n_gaps     = 0;
    endtask

    task automatic track_envelope(input logic [SAMPLE_BITS-1:0] raw);
        logic [SAMPLE_BITS-1:0] mag;
        logic [SAMPLE_BITS+15:0] acc;
        logic rising;
        int unsigned gap;
        mag = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
        acc = (SAMPLE_BITS+16)'(mag) * 16 + (SAMPLE_BITS+16)'(env) * 240;
        env = SAMPLE_BITS'(acc >> 8);
        rising = env > env_prev;
        // peak: envelope stopped rising after a rise
        if (!rising && rose_prev && n_taken > 0) begin
            if (anchor == 0) begin
                anchor = n_taken;
            end else begin
                gap = n_taken - anchor;
                if (gap >= GAP_LO_S * rate_hz && gap <= GAP_HI_S * rate_hz) begin
                    gap_sum += gap;
                    n_gaps++;
                    anchor = n_taken;
                end
            end
        end
        env_prev   = env;
        rose_prev  = rising;
        n_taken++;
    endtask

    function automatic t_rate_report window_report();
        t_rate_report r;
        int unsigned avg;
        int unsigned bpm_calc;
        r = '0;
        if (rate_hz == 0) begin
            r.status = ST_BAD_CFG;
        end else if (n_taken < MIN_WINDOW_S * rate_hz) begin
            r.status = ST_SHORT;
        end else if (n_gaps < MIN_INTERVALS) begin
            r.status = ST_FEW_PEAKS;
        end else begin
            avg = gap_sum / n_gaps;
            if (avg == 0) begin
                r.status = ST_BAD_CFG;
            end else begin
                bpm_calc = (SEC_PER_MIN * rate_hz) / avg;
                if (bpm_calc < BPM_MIN || bpm_calc > BPM_MAX) begin
                    r.status = ST_RANGE;
                end else begin
                    r.status = ST_OK;
                    r.bpm    = BPM_W'(bpm_calc);
                    r.conf   = (n_gaps >= CONF_FULL_N) ? CONF_W'(CONF_MAX)
                                                       : CONF_W'(n_gaps * CONF_STEP);
                end
            end
        end
        return r;
    endfunction

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        o_ok_results = 0;
        rate_hz      = RATE_RESET;
        clear_window();
    end

    always @(posedge i_clk) begin : watch
        t_rate_report got;
        t_rate_report want;
        if (!i_rst_n) begin
            rate_hz = RATE_RESET;
            clear_window();
            reports_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_bpm, i_conf};
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected result beat: status %0d bpm %0d conf %0d",
                             $time, got.status, got.bpm, got.conf);
                    o_errors++;
                end else begin
                    want = reports_due.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        o_errors++;
                    end
                    if (got.bpm != want.bpm) begin
                        $display("%0t: breaths_per_minute expected %0d actual %0d",
                                 $time, want.bpm, got.bpm);
                        o_errors++;
                    end
                    if (got.conf != want.conf) begin
                        $display("%0t: confidence_percent expected %0d actual %0d",
                                 $time, want.conf, got.conf);
                        o_errors++;
                    end
                    if (got == want && want.status == ST_OK) begin
                        o_ok_results++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                rate_hz = i_cfg_rate;
            end
            if (i_in_valid && i_in_ready) begin
                // samples past the window limit are dropped, the last flag still counts
                if (n_taken < MAX_SAMPLES) begin
                    track_envelope(i_sample);
                end
                if (i_last) begin
                    reports_due.push_back(window_report());
                    clear_window();
                end
            end
        end
        o_pending = reports_due.size();
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for the respiration rate estimator: stimulus, flow control and verdict.
module tb_top;
    import rre_pkg::*;

    localparam int MAX_SAMPLES   = 256;
    localparam int SAMPLE_BITS   = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int PER_SETTING   = 100;
    localparam int BURST_PERIOD  = 40;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [RATE_W-1:0]      i_cfg_sample_rate_hz;
    logic                   i_valid;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_ac_sample;
    logic                   i_last_sample;
    logic                   o_valid;
    logic                   i_ready;
    logic [STATUS_W-1:0]    o_status;
    logic [BPM_W-1:0]       o_breaths_per_minute;
    logic [CONF_W-1:0]      o_confidence_percent;

    int   fails;
    int   pending;
    int   ok_results;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_req;
    logic hold_taken;
    int   n_samples;
    int   n_windows;
    int   n_settings;

    respiration_rate_estimator #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_sample_rate_hz (i_cfg_sample_rate_hz),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_ac_sample          (i_ac_sample),
        .i_last_sample        (i_last_sample),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_breaths_per_minute (o_breaths_per_minute),
        .o_confidence_percent (o_confidence_percent)
    );

    rre_result_checker #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_report_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_rate   (i_cfg_sample_rate_hz),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_sample     (i_ac_sample),
        .i_last       (i_last_sample),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_status     (o_status),
        .i_bpm        (o_breaths_per_minute),
        .i_conf       (o_confidence_percent),
        .o_errors     (fails),
        .o_pending    (pending),
        .o_ok_results (ok_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial begin
        i_ready    = 1'b0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_ac_sample   <= s;
        i_last_sample <= last;
        do @(posedge i_clk); while (!o_ready);
        n_samples++;
        if (last) n_windows++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] r);
        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_sample_rate_hz <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] loud();
        int amp;
        amp = $urandom_range(8388607, 1 << 16);
        return $urandom_range(1) ? SAMPLE_BITS'(-amp) : SAMPLE_BITS'(amp);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] quiet();
        int v;
        v = $urandom_range(510);
        return SAMPLE_BITS'(v - 255);
    endfunction

    // bursts every period samples, quiet in between
    task automatic send_breaths(input int period, input int burst, input int len);
        logic [SAMPLE_BITS-1:0] s;
        for (int i = 0; i < len; i++) begin
            if ((i % period) < burst) s = loud();
            else if ($urandom_range(3) == 0) s = quiet();
            else s = '0;
            send_sample(s, i == len - 1);
        end
    endtask

    task automatic random_window(input int r);
        int pick;
        int period;
        int burst;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 85) period = $urandom_range(10 * r, 2 * r);
        else period = $urandom_range(12 * r, 1);
        burst = $urandom_range(period > 3 ? 3 : (period > 1 ? period - 1 : 1), 1);
        if (pick < 70) begin
            send_breaths(period, burst, MIN_WINDOW_S * r + $urandom_range(15 * r));
        end else if (pick < 85) begin
            send_breaths(period, burst, $urandom_range(MIN_WINDOW_S * r - 1, 1));
        end else begin
            pick = $urandom_range(25 * r, 1);
            for (int i = 0; i < pick; i++) begin
                send_sample(SAMPLE_BITS'($urandom()), i == pick - 1);
            end
        end
    endtask

    initial begin
        int r;
        int goal;
        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_sample_rate_hz = '0;
        i_valid              = 1'b0;
        i_ac_sample          = '0;
        i_last_sample        = 1'b0;
        hold_req             = 1'b0;
        send_idle_pct        = 13;
        recv_idle_pct        = 81;
        n_samples            = 0;
        n_windows            = 0;
        n_settings           = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at the reset rate, one-sample window, zero rate and a rate of 1000
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h000001, 1'b0);
        send_sample(24'h800000, 1'b1);
        write_rate(RATE_W'(0));
        send_sample(24'h400000, 1'b0);
        send_sample(24'hC00000, 1'b0);
        send_sample(24'h000000, 1'b1);
        write_rate(RATE_W'(1000));
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h000000, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 13 : 0;
            for (int k = 0; k < 3; k++) begin
                r = ($urandom_range(9) == 0) ? 4 : $urandom_range(3, 1);
                write_rate(RATE_W'(r));
                goal = n_samples + PER_SETTING;
                while (n_samples < goal) random_window(r);
            end
        end

        // receiver stalls long while short windows keep coming
        write_rate(RATE_W'(1));
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_sample(loud(), 1'b0);
            send_sample(quiet(), 1'b1);
        end

        // window longer than the sample limit, with regular breaths
        write_rate(RATE_W'(10));
        for (int i = 0; i <= MAX_SAMPLES + 10; i++) begin
            send_sample((i % BURST_PERIOD) == 5 ? loud() : '0, i == MAX_SAMPLES + 10);
        end

        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Run: %0d samples, %0d windows, %0d rate writes, one window past the limit.",
                 n_samples, n_windows, n_settings);
        $display("Windows that yielded a valid rate: %0d", ok_results);
        if (fails == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- respiration_rate_estimator.f -----
rtl/rre_pkg.sv
rtl/rre_div.sv
rtl/respiration_rate_estimator.sv
test/rre_result_checker.sv
test/tb_top.sv
